FILE: hdl/stereo_hermite_resampler_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stereo Hermite resampler
// Shared concurrent assertion forms on the core clock and reset.
// ----------------------------------------------------------------------------
`ifndef STEREO_HERMITE_RESAMPLER_CORE_MACROS_SVH
`define STEREO_HERMITE_RESAMPLER_CORE_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define SHR_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the core clock and reset.
`define SHR_ASSERT(lbl, prop, msg) \
  `SHR_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: hdl/shr_pkg.sv
// ----------------------------------------------------------------------------
// shr_pkg
// Types, constants and arithmetic helpers for the stereo Hermite resampler.
// ----------------------------------------------------------------------------
package shr_pkg;

  localparam int unsigned SampleW       = 32;
  localparam int unsigned PhaseFracBits = 16;
  localparam int unsigned StepW         = 18;
  // phase < one sample plus a full step always fits
  localparam int unsigned PhaseW        = StepW + 1;
  localparam logic [PhaseW-1:0] PhaseOne = PhaseW'(1) << PhaseFracBits;
  localparam logic [StepW-1:0]  StepReset = StepW'(4096);

  localparam int unsigned MaxOutPerIn = 16;
  localparam int unsigned CntW        = $clog2(MaxOutPerIn);

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);

  // APB register map
  localparam int unsigned PaddrW   = 3;
  localparam int unsigned PdataW   = 32;
  localparam int unsigned CfgIdxW  = PaddrW - 2;
  localparam logic [CfgIdxW-1:0] RegPhaseStep = CfgIdxW'(0);

  typedef struct packed {
    logic signed [SampleW-1:0] left_sample;
    logic signed [SampleW-1:0] right_sample;
  } shr_in_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] left_out;
    logic signed [SampleW-1:0] right_out;
    logic                      last_of_run;
  } shr_out_item_t;

  // cubic coefficients of one channel plus the base sample
  typedef struct packed {
    logic [SampleW-1:0] c3;
    logic [SampleW-1:0] c2;
    logic [SampleW-1:0] c1;
    logic [SampleW-1:0] x2;
  } shr_coef_t;

  typedef struct packed {
    shr_coef_t left;
    shr_coef_t right;
  } shr_item_t;

  // one Horner stage of one channel
  typedef struct packed {
    logic [SampleW-1:0] acc;
    logic [SampleW-1:0] c1;
    logic [SampleW-1:0] x2;
  } shr_stage_t;

  function automatic logic [SampleW-1:0] asr1(input logic [SampleW-1:0] x);
    return {x[SampleW-1], x[SampleW-1:1]};
  endfunction

  // Q31 multiply by a fraction that holds PhaseFracBits significant bits
  function automatic logic [SampleW-1:0] qmul(input logic [SampleW-1:0]       a,
                                              input logic [PhaseFracBits-1:0] f);
    logic signed [SampleW+PhaseFracBits:0] prod;
    prod = $signed(a) * $signed({1'b0, f});
    return prod[PhaseFracBits +: SampleW];
  endfunction

  // Catmull-Rom coefficients, x3 oldest, x0 newest
  function automatic shr_coef_t coef(input logic [SampleW-1:0] x3,
                                     input logic [SampleW-1:0] x2,
                                     input logic [SampleW-1:0] x1,
                                     input logic [SampleW-1:0] x0);
    shr_coef_t          c;
    logic [SampleW-1:0] v;
    v    = x1 - x2;
    c.c1 = asr1(x1 - x3);
    c.c2 = x3 + {v[SampleW-2:0], 1'b0} - asr1(x0 + x2);
    c.c3 = asr1(x0 - x3 - v) - v;
    c.x2 = x2;
    return c;
  endfunction

endpackage

FILE: hdl/shr_front.sv
// ----------------------------------------------------------------------------
// shr_front
// Accepts input items, keeps the sample history and derives the per-item
// cubic coefficients that go to the queue.
// ----------------------------------------------------------------------------
module shr_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  shr_pkg::shr_in_item_t in_item_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output shr_pkg::shr_item_t    push_item_o
);

  logic [shr_pkg::SampleW-1:0] left_hist_q  [3];
  logic [shr_pkg::SampleW-1:0] left_hist_d  [3];
  logic [shr_pkg::SampleW-1:0] right_hist_q [3];
  logic [shr_pkg::SampleW-1:0] right_hist_d [3];
  logic                        accept;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i && push_ready_i;

  assign push_item_o.left  = shr_pkg::coef(left_hist_q[0], left_hist_q[1],
                                           left_hist_q[2], in_item_i.left_sample);
  assign push_item_o.right = shr_pkg::coef(right_hist_q[0], right_hist_q[1],
                                           right_hist_q[2], in_item_i.right_sample);

  always_comb begin
    left_hist_d  = left_hist_q;
    right_hist_d = right_hist_q;
    if (accept) begin
      left_hist_d[0]  = left_hist_q[1];
      left_hist_d[1]  = left_hist_q[2];
      left_hist_d[2]  = in_item_i.left_sample;
      right_hist_d[0] = right_hist_q[1];
      right_hist_d[1] = right_hist_q[2];
      right_hist_d[2] = in_item_i.right_sample;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        left_hist_q[i]  <= '0;
        right_hist_q[i] <= '0;
      end
    end else begin
      left_hist_q  <= left_hist_d;
      right_hist_q <= right_hist_d;
    end
  end

endmodule

FILE: hdl/shr_queue.sv
// ----------------------------------------------------------------------------
// shr_queue
// Short FIFO of coefficient records between front and back.
// ----------------------------------------------------------------------------
module shr_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  shr_pkg::shr_item_t push_item_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output shr_pkg::shr_item_t pop_item_o
);

  localparam int unsigned CntQW = $clog2(shr_pkg::QueueDepth + 1);

  shr_pkg::shr_item_t          mem_q [shr_pkg::QueueDepth];
  logic [shr_pkg::QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [shr_pkg::QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntQW-1:0]            cnt_q, cnt_d;
  logic                        do_push, do_pop;

  assign push_ready_o = (cnt_q != CntQW'(shr_pkg::QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

FILE: hdl/shr_back.sv
// ----------------------------------------------------------------------------
// shr_back
// Phase sequencer plus a three-stage Horner pipeline per channel ending in the
// output register. The whole pipe advances when the output slot frees.
// ----------------------------------------------------------------------------
module shr_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [shr_pkg::StepW-1:0]     step_i,
  input  logic                          pop_valid_i,
  output logic                          pop_ready_o,
  input  shr_pkg::shr_item_t            pop_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output shr_pkg::shr_out_item_t        out_item_o
);

  localparam int unsigned FracW = shr_pkg::PhaseFracBits;

  // sequencer
  logic                         busy_q, busy_d;
  shr_pkg::shr_item_t           cur_q;
  logic [shr_pkg::PhaseW-1:0]   phase_q, phase_d, phase_sum;
  logic [shr_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic                         load, produce, issue, last, done, advance;
  logic [FracW-1:0]             frac;

  // pipeline
  logic                         s1_valid_q, s2_valid_q, out_valid_q;
  logic                         s1_last_q, s2_last_q;
  logic [FracW-1:0]             s1_frac_q, s2_frac_q;
  shr_pkg::shr_stage_t          s1_l_q, s1_r_q, s2_l_q, s2_r_q;
  shr_pkg::shr_out_item_t       out_item_q;

  assign advance   = !out_valid_q || out_ready_i;
  assign load      = pop_valid_i && !busy_q;
  assign pop_ready_o = !busy_q;
  assign produce   = busy_q && (phase_q < shr_pkg::PhaseOne);
  assign phase_sum = phase_q + shr_pkg::PhaseW'(step_i);
  assign last      = (phase_sum >= shr_pkg::PhaseOne) ||
                     (cnt_q == shr_pkg::CntW'(shr_pkg::MaxOutPerIn - 1));
  assign issue     = produce && advance;
  assign done      = busy_q && (!produce || (issue && last));
  assign frac      = phase_q[FracW-1:0];

  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    if (done) begin
      busy_d = 1'b0;
      cnt_d  = '0;
      if (!produce) begin
        // downsampling: item gives no output
        phase_d = phase_q - shr_pkg::PhaseOne;
      end else if (phase_sum >= shr_pkg::PhaseOne) begin
        phase_d = phase_sum - shr_pkg::PhaseOne;
      end else begin
        // output cap hit below one whole sample
        phase_d = '0;
      end
    end else if (issue) begin
      phase_d = phase_sum;
      cnt_d   = cnt_q + 1'b1;
    end else if (load) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      phase_q     <= '0;
      cnt_q       <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      if (advance) begin
        s1_valid_q  <= issue;
        s2_valid_q  <= s1_valid_q;
        out_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= pop_item_i;
    end
    if (advance) begin
      // stage 1: c3 * f + c2
      s1_last_q <= last;
      s1_frac_q <= frac;
      s1_l_q.acc <= shr_pkg::qmul(cur_q.left.c3, frac) + cur_q.left.c2;
      s1_l_q.c1  <= cur_q.left.c1;
      s1_l_q.x2  <= cur_q.left.x2;
      s1_r_q.acc <= shr_pkg::qmul(cur_q.right.c3, frac) + cur_q.right.c2;
      s1_r_q.c1  <= cur_q.right.c1;
      s1_r_q.x2  <= cur_q.right.x2;
      // stage 2: acc * f + c1
      s2_last_q <= s1_last_q;
      s2_frac_q <= s1_frac_q;
      s2_l_q.acc <= shr_pkg::qmul(s1_l_q.acc, s1_frac_q) + s1_l_q.c1;
      s2_l_q.c1  <= s1_l_q.c1;
      s2_l_q.x2  <= s1_l_q.x2;
      s2_r_q.acc <= shr_pkg::qmul(s1_r_q.acc, s1_frac_q) + s1_r_q.c1;
      s2_r_q.c1  <= s1_r_q.c1;
      s2_r_q.x2  <= s1_r_q.x2;
      // stage 3: acc * f + x2
      out_item_q.left_out    <= shr_pkg::qmul(s2_l_q.acc, s2_frac_q) + s2_l_q.x2;
      out_item_q.right_out   <= shr_pkg::qmul(s2_r_q.acc, s2_frac_q) + s2_r_q.x2;
      out_item_q.last_of_run <= s2_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

FILE: hdl/stereo_hermite_resampler_core.sv
// ----------------------------------------------------------------------------
// stereo_hermite_resampler_core
// Streaming stereo 4-point Catmull-Rom resampler with an APB step register.
// ----------------------------------------------------------------------------
// Each input item carries one left and one right sample; each output item is
// one interpolated pair, with last_of_run set on the final output of the
// input item that caused it. The front keeps the three-sample history and
// computes the cubic coefficients for both channels in the cycle the item is
// taken; the record then waits in a two-entry queue, so the input side keeps
// accepting while the back is busy. The back owns the 3.16 phase: it loads
// a record when idle, then issues one output per cycle while the phase is
// below one sample and the output is not stalled (at most 16 per item),
// adding phase_step each time; it takes the next record only after the
// current one is done. An item that makes none (downsampling) is dropped
// and lowers the phase by one sample. The sequencer issue rate, one output
// per cycle, is the throughput limit. Each output runs through a three-stage
// Horner pipeline (one multiplier per channel per stage) whose last stage is
// the output register. A stall on the output freezes the whole back pipe.
// phase_step sits at APB byte address 0, resets to 4096 (48 kHz to 768 kHz)
// and must only be written while the block is idle.
// ----------------------------------------------------------------------------
module stereo_hermite_resampler_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input samples
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  shr_pkg::shr_in_item_t         in_item_i,
  // interpolated outputs
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output shr_pkg::shr_out_item_t        out_item_o,
  // APB configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [shr_pkg::PaddrW-1:0]    paddr,
  input  logic [shr_pkg::PdataW-1:0]    pwdata,
  output logic [shr_pkg::PdataW-1:0]    prdata,
  output logic                          pready
);

  logic [shr_pkg::StepW-1:0]   step_q, step_d;
  logic [shr_pkg::CfgIdxW-1:0] reg_idx;
  logic                        cfg_wr;

  logic                        push_valid, push_ready;
  shr_pkg::shr_item_t          push_item;
  logic                        pop_valid, pop_ready;
  shr_pkg::shr_item_t          pop_item;

  // ---------------------------------------------------------------- APB ---
  assign pready  = 1'b1;
  assign reg_idx = paddr[shr_pkg::PaddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    step_d = step_q;
    if (cfg_wr && (reg_idx == shr_pkg::RegPhaseStep)) begin
      step_d = pwdata[shr_pkg::StepW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= shr_pkg::StepReset;
    end else begin
      step_q <= step_d;
    end
  end

  // unmapped addresses read as zero
  always_comb begin
    unique case (reg_idx)
      shr_pkg::RegPhaseStep: prdata = shr_pkg::PdataW'(step_q);
      default:               prdata = '0;
    endcase
  end

  // -------------------------------------------------------- datapath -----
  shr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  shr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  shr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: hdl/shr_checker.sv
// ----------------------------------------------------------------------------
// shr_checker
// Port-level checks on the resampler core, bound to the top level.
// ----------------------------------------------------------------------------
`include "stereo_hermite_resampler_core_macros.svh"

module shr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input shr_pkg::shr_in_item_t         in_item_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input shr_pkg::shr_out_item_t        out_item_o,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [shr_pkg::PaddrW-1:0]    paddr,
  input logic [shr_pkg::PdataW-1:0]    pwdata,
  input logic [shr_pkg::PdataW-1:0]    prdata,
  input logic                          pready
);

  logic                                      in_stall;
  logic                                      out_stall;
  logic                                      step_sel;
  logic                                      step_wr;
  logic [shr_pkg::StepW-1:0]                 rd_step;
  logic [shr_pkg::StepW-1:0]                 wr_step;
  logic [shr_pkg::PdataW-shr_pkg::StepW-1:0] rd_high;

  assign in_stall  = in_valid_i && !in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;
  assign step_sel  = (paddr[shr_pkg::PaddrW-1:2] == shr_pkg::RegPhaseStep);
  assign step_wr   = psel && penable && pwrite && pready && step_sel;
  assign rd_step   = prdata[shr_pkg::StepW-1:0];
  assign wr_step   = pwdata[shr_pkg::StepW-1:0];
  assign rd_high   = prdata[shr_pkg::PdataW-1:shr_pkg::StepW];

  // a stalled result holds
  `SHR_ASSERT(a_out_hold, out_stall |=> out_valid_o && $stable(out_item_o), "output item moved")

  // a waiting input item holds
  `SHR_ASSERT(a_in_hold, in_stall |=> in_valid_i && $stable(in_item_i), "input item dropped")

  // the step register reads back what was written
  `SHR_ASSERT(a_step_readback, step_wr |=> !step_sel || (rd_step == $past(wr_step)), "step readback")

  // only 18 bits of the step are stored
  `SHR_ASSERT(a_prdata_upper, rd_high == '0, "prdata upper bits not zero")

  // the port never inserts wait states
  `SHR_ASSERT(a_pready_high, pready, "pready dropped")

endmodule

bind stereo_hermite_resampler_core shr_checker u_checker (.*);
